// ===== rtl/scq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scq_pkg
// Shared types and constants for the sorted cost queue: command and result
// payloads, the stored entry layout, the controller states and the status
// group passed from the controller to the result stage.
// ----------------------------------------------------------------------------
package scq_pkg;

    // Field widths of the payloads
    localparam int NODE_BITS      = 16;
    localparam int COST_BITS      = 32;
    localparam int OUT_COUNT_BITS = 7;
    localparam int ENTRY_BITS     = NODE_BITS + COST_BITS;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    // One command transfer
    typedef struct packed
    {
        op_t                  operation;
        logic [NODE_BITS-1:0] node_id;
        logic [COST_BITS-1:0] cost;
    } cmd_t;

    // One result transfer
    typedef struct packed
    {
        logic                      front_valid;
        logic [NODE_BITS-1:0]      front_node;
        logic [COST_BITS-1:0]      front_cost;
        logic [OUT_COUNT_BITS-1:0] occupancy;
        logic [OUT_COUNT_BITS-1:0] removed_count;
        logic                      overflow;
    } result_t;

    // Layout of one memory word
    typedef struct packed
    {
        logic [NODE_BITS-1:0] node;
        logic [COST_BITS-1:0] cost;
    } entry_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_INS_SCAN,
        ST_REM_SCAN,
        ST_FRONT_RD,
        ST_FRONT_OUT
    } scq_state_t;

    // Status from the controller when the front entry is on the read port
    typedef struct packed
    {
        logic                      valid;
        logic                      has_entry;
        logic [OUT_COUNT_BITS-1:0] occupancy;
        logic [OUT_COUNT_BITS-1:0] removed;
        logic                      overflow;
    } scq_fin_t;

endpackage

// ===== rtl/scq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scq_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module scq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/scq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scq_ctrl
// Sequencer of the sorted cost queue. An insert walks the stored entries
// from the back, moving each costlier entry one slot up until the insert
// point is found. A remove walks from the front and compacts the kept
// entries downward. Both finish by reading slot 0 for the result.
// ----------------------------------------------------------------------------
module scq_ctrl #(
    parameter int CAPACITY = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  scq_pkg::cmd_t                 cmd,
    output logic                          ram_we,
    output logic [$clog2(CAPACITY)-1:0]   ram_waddr,
    output logic [scq_pkg::ENTRY_BITS-1:0] ram_wdata,
    output logic                          ram_re,
    output logic [$clog2(CAPACITY)-1:0]   ram_raddr,
    input  logic [scq_pkg::ENTRY_BITS-1:0] ram_rdata,
    output scq_pkg::scq_fin_t             fin
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    scq_pkg::scq_state_t            state_reg, state_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [CW-1:0]                  left_reg, left_next;
    logic [CW-1:0]                  wr_cnt_reg, wr_cnt_next;
    logic [CW-1:0]                  removed_reg, removed_next;
    logic [AW-1:0]                  rd_idx_reg, rd_idx_next;
    logic [AW-1:0]                  pend_idx_reg, pend_idx_next;
    logic                           pend_reg, pend_next;
    logic                           ovf_reg, ovf_next;
    logic [scq_pkg::NODE_BITS-1:0]  node_reg, node_next;
    logic [scq_pkg::COST_BITS-1:0]  cost_reg, cost_next;

    scq_pkg::entry_t                rd_entry;
    scq_pkg::entry_t                new_entry;
    logic                           costlier;
    logic                           finish;

    assign rd_entry  = scq_pkg::entry_t'(ram_rdata);
    assign new_entry = '{node: node_reg, cost: cost_reg};
    assign costlier  = rd_entry.cost > cost_reg;
    assign busy      = state_reg != scq_pkg::ST_IDLE;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= scq_pkg::ST_IDLE;
            count_reg   <= '0;
            left_reg    <= '0;
            wr_cnt_reg  <= '0;
            removed_reg <= '0;
            rd_idx_reg  <= '0;
            pend_idx_reg <= '0;
            pend_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            left_reg    <= left_next;
            wr_cnt_reg  <= wr_cnt_next;
            removed_reg <= removed_next;
            rd_idx_reg  <= rd_idx_next;
            pend_idx_reg <= pend_idx_next;
            pend_reg    <= pend_next;
            ovf_reg     <= ovf_next;
        end
    end

    // Command payload
    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        cost_reg <= cost_next;
    end

    // Next state, scan datapath and memory requests
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        left_next     = left_reg;
        wr_cnt_next   = wr_cnt_reg;
        removed_next  = removed_reg;
        rd_idx_next   = rd_idx_reg;
        pend_idx_next = pend_idx_reg;
        pend_next     = 1'b0;
        ovf_next      = ovf_reg;
        node_next     = node_reg;
        cost_next     = cost_reg;
        finish        = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = new_entry;
        ram_re        = 1'b0;
        ram_raddr     = '0;
        fin           = '0;

        case (state_reg)
            scq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    node_next    = cmd.node_id;
                    cost_next    = cmd.cost;
                    ovf_next     = 1'b0;
                    removed_next = '0;
                    left_next    = count_reg;
                    wr_cnt_next  = '0;
                    rd_idx_next  = '0;
                    if (cmd.operation == scq_pkg::OP_REMOVE)
                    begin
                        state_next = scq_pkg::ST_REM_SCAN;
                    end
                    else if (count_reg == CW'(CAPACITY))
                    begin
                        // full: drop the entry
                        ovf_next   = 1'b1;
                        state_next = scq_pkg::ST_FRONT_RD;
                    end
                    else
                    begin
                        state_next = scq_pkg::ST_INS_SCAN;
                    end
                end
            end

            scq_pkg::ST_INS_SCAN:
            begin
                // walk down from the back; stop at the first entry not costlier
                finish = (pend_reg && !costlier) || (!pend_reg && left_reg == '0);
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_idx_reg + AW'(1);
                    ram_wdata = costlier ? rd_entry : new_entry;
                end
                else if (finish)
                begin
                    // every held entry is costlier: new entry goes to the front
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                end
                if (finish)
                begin
                    count_next = count_reg + CW'(1);
                    state_next = scq_pkg::ST_FRONT_RD;
                end
                else if (left_reg != '0)
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = AW'(left_reg - CW'(1));
                    pend_idx_next = AW'(left_reg - CW'(1));
                    left_next     = left_reg - CW'(1);
                    pend_next     = 1'b1;
                end
            end

            scq_pkg::ST_REM_SCAN:
            begin
                // reads run ahead of the compacting write pointer
                if (left_reg != '0)
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = rd_idx_reg;
                    rd_idx_next = rd_idx_reg + AW'(1);
                    left_next   = left_reg - CW'(1);
                    pend_next   = 1'b1;
                end
                if (pend_reg && rd_entry.node != node_reg)
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = wr_cnt_reg[AW-1:0];
                    ram_wdata   = rd_entry;
                    wr_cnt_next = wr_cnt_reg + CW'(1);
                end
                if (!pend_reg && left_reg == '0)
                begin
                    count_next   = wr_cnt_reg;
                    removed_next = count_reg - wr_cnt_reg;
                    state_next   = scq_pkg::ST_FRONT_RD;
                end
            end

            scq_pkg::ST_FRONT_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                state_next = scq_pkg::ST_FRONT_OUT;
            end

            scq_pkg::ST_FRONT_OUT:
            begin
                fin.valid     = 1'b1;
                fin.has_entry = count_reg != '0;
                fin.occupancy = scq_pkg::OUT_COUNT_BITS'(count_reg);
                fin.removed   = scq_pkg::OUT_COUNT_BITS'(removed_reg);
                fin.overflow  = ovf_reg;
                state_next    = scq_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = scq_pkg::ST_IDLE;
            end
        endcase
    end

    // Checks
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("occupancy above capacity");

    a_ovf_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == scq_pkg::ST_IDLE && start && cmd.operation == scq_pkg::OP_INSERT
         && count_reg == CW'(CAPACITY)) |=> (count_reg == $past(count_reg) && ovf_reg))
        else $error("dropped insert changed occupancy");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == scq_pkg::ST_REM_SCAN) |=> count_reg <= $past(count_reg))
        else $error("remove grew occupancy");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == scq_pkg::ST_IDLE || state_reg == scq_pkg::ST_FRONT_OUT) |-> !ram_we)
        else $error("memory write outside a scan");

    a_compact_behind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == scq_pkg::ST_REM_SCAN) |-> wr_cnt_reg <= count_reg - left_reg)
        else $error("compaction write pointer ran ahead of reads");

endmodule

// ===== rtl/sorted_cost_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_cost_queue
// Bounded queue of (node, cost) entries kept in rising cost order in one
// RAM. Inserts go after equal costs; removes delete every entry of a node.
// Each command yields one result with the front entry and counters.
//
//   channel   ports                     direction  transfer
//   command   start, busy, cmd          in         start && !busy
//   result    result_strobe, result     out        result_strobe (one cycle)
//
// An insert scans the held entries costlier than the new one, stopping at
// the first that is not; a remove scans every held entry; a dropped insert
// on a full queue skips the scan and only reads the front. The scans are
// bound by the single read port of the entry RAM, one entry per cycle.
// Reset clears the occupancy and control state; RAM contents are not cleared.
// Results cannot be stalled; busy falls as the result is registered.
// ----------------------------------------------------------------------------
module sorted_cost_queue #(
    parameter int CAPACITY = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  scq_pkg::cmd_t     cmd,
    output logic              result_strobe,
    output scq_pkg::result_t  result
);

    localparam int AW = $clog2(CAPACITY);

    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [scq_pkg::ENTRY_BITS-1:0] ram_wdata;
    logic                           ram_re;
    logic [AW-1:0]                  ram_raddr;
    logic [scq_pkg::ENTRY_BITS-1:0] ram_rdata;
    scq_pkg::scq_fin_t              fin;
    scq_pkg::entry_t                front_entry;

    scq_pkg::result_t               result_reg, result_next;
    logic                           strobe_reg;

    scq_ram #(
        .WIDTH (scq_pkg::ENTRY_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    scq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .fin       (fin)
    );

    // Result word: front entry reads as zero on an empty queue
    assign front_entry = scq_pkg::entry_t'(ram_rdata);

    always_comb
    begin
        result_next               = result_reg;
        if (fin.valid)
        begin
            result_next.front_valid   = fin.has_entry;
            result_next.front_node    = fin.has_entry ? front_entry.node : '0;
            result_next.front_cost    = fin.has_entry ? front_entry.cost : '0;
            result_next.occupancy     = fin.occupancy;
            result_next.removed_count = fin.removed;
            result_next.overflow      = fin.overflow;
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= fin.valid;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

endmodule
